// ===== sv/psu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, filter codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int ROW_BYTES_MAX = 8192;
    localparam int COL_W         = $clog2(ROW_BYTES_MAX + 1);
    localparam int ADDR_W        = $clog2(ROW_BYTES_MAX);

    localparam int BYTE_W        = 8;
    localparam int HIST_BYTES    = 8;
    localparam int SEL_W         = $clog2(HIST_BYTES);
    localparam int BPP_W         = 4;
    localparam logic [BPP_W-1:0] BPP_RESET = 4'd1;
    localparam logic [BPP_W-1:0] BPP_MAX   = 4'd8;

    localparam int OUTQ_DEPTH    = 3;
    localparam int OUTQ_PTR_W    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

    localparam int PADDR_W       = 2;
    localparam int PDATA_W       = 32;
    localparam logic [PADDR_W-1:0] REG_BPP_ADDR = 2'd0;

    localparam logic [7:0] FT_NONE  = 8'd0;
    localparam logic [7:0] FT_SUB   = 8'd1;
    localparam logic [7:0] FT_UP    = 8'd2;
    localparam logic [7:0] FT_AVG   = 8'd3;
    localparam logic [7:0] FT_PAETH = 8'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] enc;
        logic [7:0]        ftype;
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] above;
        logic [BYTE_W-1:0] upleft;
    } t_pred_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              error;
        logic              last_in_row;
    } t_out_item;

endpackage

// ===== sv/psu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter channels
// Valid/ready channels for filtered bytes in and reconstructed bytes out.
// ----------------------------------------------------------------------------
interface psu_in_if import psu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] encoded_byte;
    logic [7:0]        filter_type;
    logic              first_row;
    logic              row_end;

    modport source (output valid, encoded_byte, filter_type, first_row, row_end,
                    input ready);
    modport sink   (input valid, encoded_byte, filter_type, first_row, row_end,
                    output ready);
endinterface

interface psu_out_if import psu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              error;
    logic              last_in_row;

    modport source (output valid, out_byte, error, last_in_row, input ready);
    modport sink   (input valid, out_byte, error, last_in_row, output ready);
endinterface

// ===== sv/psu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/psu_predict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG filter predictor
// Forms the none/sub/up/average/Paeth predictor and adds it to the byte.
// ----------------------------------------------------------------------------
module psu_predict import psu_pkg::*; (
    input  t_pred_in          i_pred,
    output logic [BYTE_W-1:0] o_res,
    output logic              o_bad_type
);

    logic [BYTE_W:0]        avg_sum;
    logic signed [BYTE_W+1:0] d_bc, d_ac, d_p;
    logic [BYTE_W:0]        pa, pb, pc;
    logic [BYTE_W-1:0]      paeth;
    logic [BYTE_W-1:0]      pred;

    always_comb begin
        avg_sum = {1'b0, i_pred.left} + {1'b0, i_pred.above};

        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        d_bc = $signed({2'b00, i_pred.above}) - $signed({2'b00, i_pred.upleft});
        d_ac = $signed({2'b00, i_pred.left}) - $signed({2'b00, i_pred.upleft});
        d_p  = $signed({2'b00, i_pred.left}) + $signed({2'b00, i_pred.above})
             - $signed({1'b0, i_pred.upleft, 1'b0});
        pa = d_bc[BYTE_W+1] ? (BYTE_W+1)'(0) - d_bc[BYTE_W:0] : d_bc[BYTE_W:0];
        pb = d_ac[BYTE_W+1] ? (BYTE_W+1)'(0) - d_ac[BYTE_W:0] : d_ac[BYTE_W:0];
        pc = d_p[BYTE_W+1]  ? (BYTE_W+1)'(0) - d_p[BYTE_W:0]  : d_p[BYTE_W:0];

        if (pa <= pb && pa <= pc) begin
            paeth = i_pred.left;
        end else if (pb <= pc) begin
            paeth = i_pred.above;
        end else begin
            paeth = i_pred.upleft;
        end

        o_bad_type = 1'b0;
        case (i_pred.ftype)
            FT_NONE:  pred = '0;
            FT_SUB:   pred = i_pred.left;
            FT_UP:    pred = i_pred.above;
            FT_AVG:   pred = avg_sum[BYTE_W:1];
            FT_PAETH: pred = paeth;
            default: begin
                pred       = '0;
                o_bad_type = 1'b1;
            end
        endcase

        o_res = o_bad_type ? '0 : i_pred.enc + pred;
    end

endmodule

// ===== sv/psu_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output item queue
// Small register queue that decouples the datapath from output stalls.
// ----------------------------------------------------------------------------
module psu_out_fifo import psu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_out_item             i_item,
    output logic [OUTQ_CNT_W-1:0] o_count,
    psu_out_if.source             o_out
);

    t_out_item               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [OUTQ_CNT_W-1:0]   r_cnt, n_cnt;
    logic                    pop;
    t_out_item               head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_count           = r_cnt;
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = head.out_byte;
    assign o_out.error       = head.error;
    assign o_out.last_in_row = head.last_in_row;

endmodule

// ===== sv/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs filtered PNG scanlines one byte per item, keeping the previous
// row in a line store that is overwritten in place as the row goes by.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the read stage, then the output queue register,
// before it can leave. Throughput: one item per cycle while the output queue
// has room, set by the left-neighbour loop through the predictor and the single
// read and write port of the line store.
// Reset: clears column count, histories, pipeline and queue; the pixel stride
// register returns to 1. The line store is not cleared and needs no clearing pass.
module png_scanline_unfilter import psu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // item channels
    psu_in_if.sink             i_in,
    psu_out_if.source          o_out
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [BPP_W-1:0] r_bpp;
    logic [BPP_W-1:0] bpp_eff;
    logic [SEL_W-1:0] hist_sel;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_BPP_ADDR);
    assign prdata = (paddr == REG_BPP_ADDR) ? {{(PDATA_W - BPP_W){1'b0}}, r_bpp} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= BPP_RESET;
        end else if (cfg_wr) begin
            r_bpp <= pwdata[BPP_W-1:0];
        end
    end

    // Clamp: zero acts as one pixel byte, anything above eight as eight.
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (r_bpp > BPP_MAX) begin
            bpp_eff = BPP_MAX;
        end else begin
            bpp_eff = r_bpp;
        end
        hist_sel = SEL_W'(bpp_eff - 1'b1);
    end

    // ------------------------------------------------------------------
    // Accept stage: issue the line store read at the current column
    // ------------------------------------------------------------------
    logic                  acc;
    logic [COL_W-1:0]      r_col, n_col;
    logic                  a_in_store;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0]   q_used;
    logic                  r_b_valid;

    // Reserve queue room for the item in the read stage and the new one;
    // hold ready low while in reset.
    assign q_used     = {1'b0, q_count} + {{OUTQ_CNT_W{1'b0}}, r_b_valid};
    assign i_in.ready = i_rst_n && (q_used < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
    assign acc        = i_in.valid && i_in.ready;
    assign a_in_store = (r_col < COL_W'(ROW_BYTES_MAX));

    // Column count: back to zero on row end, saturate past the store.
    always_comb begin
        n_col = r_col;
        if (acc) begin
            if (i_in.row_end) begin
                n_col = '0;
            end else if (a_in_store) begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Read stage registers
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] r_b_enc;
    logic [7:0]        r_b_ftype;
    logic              r_b_first;
    logic              r_b_last;
    logic [COL_W-1:0]  r_b_col;
    logic              r_b_fwd;
    logic [BYTE_W-1:0] r_b_fwd_data;

    logic              b_in_store;
    logic [BYTE_W-1:0] b_res;
    logic              b_bad_type;
    logic              b_err;
    logic              fwd_hit;

    assign b_in_store = (r_b_col < COL_W'(ROW_BYTES_MAX));

    // The store is written in place, so a read of the column being written
    // this cycle (a one-byte row followed by the next row) takes the result.
    assign fwd_hit = r_b_valid && b_in_store && (r_b_col == r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_b_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_enc      <= i_in.encoded_byte;
            r_b_ftype    <= i_in.filter_type;
            r_b_first    <= i_in.first_row;
            r_b_last     <= i_in.row_end;
            r_b_col      <= r_col;
            r_b_fwd      <= fwd_hit;
            r_b_fwd_data <= b_res;
        end
    end

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] store_rdata;

    psu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (ROW_BYTES_MAX)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_b_valid && b_in_store),
        .i_waddr (r_b_col[ADDR_W-1:0]),
        .i_wdata (b_res),
        .i_re    (acc && a_in_store),
        .i_raddr (r_col[ADDR_W-1:0]),
        .o_rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // Neighbours and prediction
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] r_left_hist  [HIST_BYTES];
    logic [BYTE_W-1:0] r_above_hist [HIST_BYTES];
    logic [BYTE_W-1:0] b_above;
    logic              b_has_left;
    t_pred_in          pred_in;

    always_comb begin
        // Above reads zero on a first row and beyond the store.
        if (!r_b_first && b_in_store) begin
            b_above = r_b_fwd ? r_b_fwd_data : store_rdata;
        end else begin
            b_above = '0;
        end
        // Left and upper-left read zero for the first pixel of the row.
        b_has_left     = (r_b_col >= COL_W'(bpp_eff));
        pred_in.enc    = r_b_enc;
        pred_in.ftype  = r_b_ftype;
        pred_in.above  = b_above;
        pred_in.left   = b_has_left ? r_left_hist[hist_sel]  : '0;
        pred_in.upleft = b_has_left ? r_above_hist[hist_sel] : '0;
    end

    psu_predict u_predict (
        .i_pred     (pred_in),
        .o_res      (b_res),
        .o_bad_type (b_bad_type)
    );

    assign b_err = b_bad_type || !b_in_store;

    // Shift the histories by one byte per item; drop them at row end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_BYTES; k++) begin
                r_left_hist[k]  <= '0;
                r_above_hist[k] <= '0;
            end
        end else if (r_b_valid) begin
            if (r_b_last) begin
                for (int k = 0; k < HIST_BYTES; k++) begin
                    r_left_hist[k]  <= '0;
                    r_above_hist[k] <= '0;
                end
            end else begin
                r_left_hist[0]  <= b_res;
                r_above_hist[0] <= b_above;
                for (int k = 1; k < HIST_BYTES; k++) begin
                    r_left_hist[k]  <= r_left_hist[k-1];
                    r_above_hist[k] <= r_above_hist[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    t_out_item b_item;

    assign b_item.out_byte    = b_res;
    assign b_item.error       = b_err;
    assign b_item.last_in_row = r_b_last;

    psu_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b_valid),
        .i_item  (b_item),
        .o_count (q_count),
        .o_out   (o_out)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_row_end_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.row_end) |=> (r_col == '0))
        else $error("column count not cleared after row end");

    a_fwd_only_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_fwd) |-> (r_b_col == '0))
        else $error("store forwarding away from column zero");

    a_overflow_flags_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_in_store) |-> b_err)
        else $error("byte beyond line store without error");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_used <= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH))
        else $error("output queue overrun");

endmodule
